>>> design/uf_pkg.sv
// shared types and constants of the union-find engine
// no dependencies; used by uf_store, uf_seq and union_find_engine
package uf_pkg;

    localparam int NODE_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int NODES_DEF = 1024;

    localparam logic [SIZE_W-1:0] NODE_COUNT_RST = 11'd1024;

    localparam logic FUNC_UNION = 1'b0;
    localparam logic FUNC_FIND  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_NEXT,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] link_raddr;
        logic              link_we;
        logic [NODE_W-1:0] link_waddr;
        logic [NODE_W-1:0] link_wdata;
        logic [NODE_W-1:0] size_raddr;
        logic              size_we;
        logic [NODE_W-1:0] size_waddr;
        logic [SIZE_W-1:0] size_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [NODE_W-1:0] root;
        logic              merged;
        logic [SIZE_W-1:0] set_size;
        logic              bad_index;
    } t_result;

endpackage

>>> design/uf_store.sv
// parent-link and set-size memories with the clearing pass after reset
// depends on uf_pkg
module uf_store #(
    parameter int NODES = uf_pkg::NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  uf_pkg::t_mem_req              i_req,
    output logic [uf_pkg::NODE_W-1:0]     o_link_rdata,
    output logic [uf_pkg::SIZE_W-1:0]     o_size_rdata,
    output logic                          o_busy
);

    localparam int AW    = $clog2(NODES);
    localparam int CLR_N = (NODES < (1 << uf_pkg::NODE_W)) ? NODES : (1 << uf_pkg::NODE_W);
    localparam int CW    = $clog2(CLR_N);

    logic [uf_pkg::NODE_W-1:0] r_link_mem [NODES];
    logic [uf_pkg::SIZE_W-1:0] r_size_mem [NODES];
    logic [uf_pkg::NODE_W-1:0] r_link_rdata;
    logic [uf_pkg::SIZE_W-1:0] r_size_rdata;

    logic          r_clr_busy;
    logic [CW-1:0] r_clr_cnt;

    logic                      w_link_we;
    logic [AW-1:0]             w_link_waddr;
    logic [uf_pkg::NODE_W-1:0] w_link_wdata;
    logic                      w_size_we;
    logic [AW-1:0]             w_size_waddr;
    logic [uf_pkg::SIZE_W-1:0] w_size_wdata;

    // sweep every reachable entry back to a self link and size one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CW'(CLR_N - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            w_link_we    = 1'b1;
            w_link_waddr = AW'(r_clr_cnt);
            w_link_wdata = uf_pkg::NODE_W'(r_clr_cnt);
            w_size_we    = 1'b1;
            w_size_waddr = AW'(r_clr_cnt);
            w_size_wdata = uf_pkg::SIZE_W'(1);
        end else begin
            w_link_we    = i_req.link_we;
            w_link_waddr = AW'(i_req.link_waddr);
            w_link_wdata = i_req.link_wdata;
            w_size_we    = i_req.size_we;
            w_size_waddr = AW'(i_req.size_waddr);
            w_size_wdata = i_req.size_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_waddr] <= w_link_wdata;
        end
        r_link_rdata <= r_link_mem[AW'(i_req.link_raddr)];
    end

    always_ff @(posedge i_clk) begin
        if (w_size_we) begin
            r_size_mem[w_size_waddr] <= w_size_wdata;
        end
        r_size_rdata <= r_size_mem[AW'(i_req.size_raddr)];
    end

    assign o_link_rdata = r_link_rdata;
    assign o_size_rdata = r_size_rdata;
    assign o_busy       = r_clr_busy;

endmodule

>>> design/uf_seq.sv
// sequencer: root walks, path compression and the union by size
// depends on uf_pkg; drives the memories in uf_store
module uf_seq #(
    parameter int NODES = uf_pkg::NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_func,
    input  logic [uf_pkg::NODE_W-1:0] i_node_a,
    input  logic [uf_pkg::NODE_W-1:0] i_node_b,
    input  logic [uf_pkg::SIZE_W-1:0] i_node_count,
    input  logic [uf_pkg::NODE_W-1:0] i_link_rdata,
    input  logic [uf_pkg::SIZE_W-1:0] i_size_rdata,
    output uf_pkg::t_mem_req          o_req,
    output logic                      o_idle,
    output logic                      o_res_valid,
    output uf_pkg::t_result           o_res,
    input  logic                      i_res_take
);

    uf_pkg::t_state r_state, n_state;

    logic                      r_func, n_func;
    logic                      r_phase, n_phase;
    logic [uf_pkg::NODE_W-1:0] r_b, n_b;
    logic [uf_pkg::NODE_W-1:0] r_start, n_start;
    logic [uf_pkg::NODE_W-1:0] r_cur, n_cur;
    logic [uf_pkg::NODE_W-1:0] r_root, n_root;
    logic [uf_pkg::NODE_W-1:0] r_root_a, n_root_a;
    logic [uf_pkg::SIZE_W-1:0] r_size_a, n_size_a;
    uf_pkg::t_result           r_res, n_res;

    logic                      w_a_ok;
    logic                      w_b_ok;
    logic [uf_pkg::SIZE_W-1:0] w_sum;
    logic [uf_pkg::NODE_W-1:0] w_hi_root;
    logic [uf_pkg::NODE_W-1:0] w_lo_root;

    assign w_a_ok = ({1'b0, i_node_a} < i_node_count) && (32'(i_node_a) < 32'(NODES));
    assign w_b_ok = ({1'b0, i_node_b} < i_node_count) && (32'(i_node_b) < 32'(NODES));

    assign w_sum = r_size_a + i_size_rdata;

    // ties keep the first operand's root on top
    always_comb begin
        if (r_size_a < i_size_rdata) begin
            w_hi_root = r_root;
            w_lo_root = r_root_a;
        end else begin
            w_hi_root = r_root_a;
            w_lo_root = r_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_phase  <= n_phase;
        r_b      <= n_b;
        r_start  <= n_start;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_root_a <= n_root_a;
        r_size_a <= n_size_a;
        r_res    <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_phase     = r_phase;
        n_b         = r_b;
        n_start     = r_start;
        n_cur       = r_cur;
        n_root      = r_root;
        n_root_a    = r_root_a;
        n_size_a    = r_size_a;
        n_res       = r_res;
        o_req       = '0;
        o_res_valid = 1'b0;

        case (r_state)
            uf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_func  = i_func;
                    n_b     = i_node_b;
                    n_phase = 1'b0;
                    if (!w_a_ok || (i_func == uf_pkg::FUNC_UNION && !w_b_ok)) begin
                        n_res.root      = '0;
                        n_res.merged    = 1'b0;
                        n_res.set_size  = '0;
                        n_res.bad_index = 1'b1;
                        n_state         = uf_pkg::ST_DONE;
                    end else begin
                        n_start          = i_node_a;
                        n_cur            = i_node_a;
                        o_req.link_raddr = i_node_a;
                        n_state          = uf_pkg::ST_WALK;
                    end
                end
            end

            // one parent hop per cycle until a self link
            uf_pkg::ST_WALK: begin
                if (i_link_rdata == r_cur) begin
                    n_root = r_cur;
                    if (r_start == r_cur) begin
                        n_state = uf_pkg::ST_NEXT;
                    end else begin
                        n_cur            = r_start;
                        o_req.link_raddr = r_start;
                        n_state          = uf_pkg::ST_COMP;
                    end
                end else begin
                    n_cur            = i_link_rdata;
                    o_req.link_raddr = i_link_rdata;
                end
            end

            // second walk: repoint each node on the path at the root
            uf_pkg::ST_COMP: begin
                o_req.link_we    = 1'b1;
                o_req.link_waddr = r_cur;
                o_req.link_wdata = r_root;
                if (i_link_rdata == r_root) begin
                    n_state = uf_pkg::ST_NEXT;
                end else begin
                    n_cur            = i_link_rdata;
                    o_req.link_raddr = i_link_rdata;
                end
            end

            uf_pkg::ST_NEXT: begin
                if (!r_phase) begin
                    n_root_a = r_root;
                end
                if (!r_phase && r_func == uf_pkg::FUNC_UNION) begin
                    n_phase          = 1'b1;
                    n_start          = r_b;
                    n_cur            = r_b;
                    o_req.link_raddr = r_b;
                    n_state          = uf_pkg::ST_WALK;
                end else begin
                    o_req.size_raddr = r_phase ? r_root_a : r_root;
                    n_state          = uf_pkg::ST_SIZE_A;
                end
            end

            uf_pkg::ST_SIZE_A: begin
                n_size_a = i_size_rdata;
                if (r_func == uf_pkg::FUNC_FIND || r_root_a == r_root) begin
                    n_res.root      = r_root_a;
                    n_res.merged    = 1'b0;
                    n_res.set_size  = i_size_rdata;
                    n_res.bad_index = 1'b0;
                    n_state         = uf_pkg::ST_DONE;
                end else begin
                    o_req.size_raddr = r_root;
                    n_state          = uf_pkg::ST_SIZE_B;
                end
            end

            uf_pkg::ST_SIZE_B: begin
                o_req.link_we    = 1'b1;
                o_req.link_waddr = w_lo_root;
                o_req.link_wdata = w_hi_root;
                o_req.size_we    = 1'b1;
                o_req.size_waddr = w_hi_root;
                o_req.size_wdata = w_sum;
                n_res.root       = w_hi_root;
                n_res.merged     = 1'b1;
                n_res.set_size   = w_sum;
                n_res.bad_index  = 1'b0;
                n_state          = uf_pkg::ST_DONE;
            end

            uf_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = uf_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = uf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == uf_pkg::ST_IDLE);
    assign o_res  = r_res;

endmodule

>>> design/union_find_engine.sv
// union-find engine top level: node count register, result register, wiring
// depends on uf_pkg, uf_store and uf_seq
//
//   channel   handshake                 payload
//   request   i_in_valid / o_in_stall   i_func i_node_a i_node_b
//   result    o_out_valid / i_out_stall o_root o_merged o_set_size o_bad_index
//   config    i_cfg_we                  i_cfg_wdata (node_count)
//
// one request at a time; a find walks its node to the root and compresses the path,
// a union two such walks plus up to two size reads, each parent hop waiting on
// a registered memory read. a request with a bad index skips the walks entirely.
// after reset a clearing pass over min(NODES, 1024) entries runs with o_in_stall high.
// a new request is taken while the previous result waits under i_out_stall.
module union_find_engine #(
    parameter int NODES = uf_pkg::NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic [uf_pkg::NODE_W-1:0] i_node_a,
    input  logic [uf_pkg::NODE_W-1:0] i_node_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [uf_pkg::NODE_W-1:0] o_root,
    output logic                      o_merged,
    output logic [uf_pkg::SIZE_W-1:0] o_set_size,
    output logic                      o_bad_index,
    input  logic                      i_cfg_we,
    input  logic [uf_pkg::SIZE_W-1:0] i_cfg_wdata
);

    logic [uf_pkg::SIZE_W-1:0] r_node_count;
    logic                      r_out_valid;
    uf_pkg::t_result           r_out;

    uf_pkg::t_mem_req          w_req;
    logic [uf_pkg::NODE_W-1:0] w_link_rdata;
    logic [uf_pkg::SIZE_W-1:0] w_size_rdata;
    logic                      w_busy;
    logic                      w_idle;
    logic                      w_start;
    logic                      w_res_valid;
    logic                      w_res_take;
    uf_pkg::t_result           w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= uf_pkg::NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    assign o_in_stall = !(w_idle && !w_busy);
    assign w_start    = i_in_valid && !o_in_stall;
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    uf_store #(
        .NODES(NODES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_link_rdata(w_link_rdata),
        .o_size_rdata(w_size_rdata),
        .o_busy      (w_busy)
    );

    uf_seq #(
        .NODES(NODES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_func      (i_func),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_node_count(r_node_count),
        .i_link_rdata(w_link_rdata),
        .i_size_rdata(w_size_rdata),
        .o_req       (w_req),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    assign o_out_valid = r_out_valid;
    assign o_root      = r_out.root;
    assign o_merged    = r_out.merged;
    assign o_set_size  = r_out.set_size;
    assign o_bad_index = r_out.bad_index;

endmodule
